// File: rtl/core/rlt_pkg.sv
// Shared types and constants for the run-length line table core.
// No dependencies; every other file in rtl/core uses this package.
`timescale 1ns / 1ps

package rlt_pkg;

    // Fixed payload widths.
    localparam int LINE_W   = 16;
    localparam int OFFSET_W = 24;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOREC = 2'd2;

    // Saturation limits of the run length and the offset count.
    localparam logic [LINE_W-1:0]   RUN_LEN_MAX = 16'hFFFF;
    localparam logic [OFFSET_W-1:0] TOTAL_MAX   = 24'hFFFFFF;

    // Configuration register indexes.
    localparam logic REG_LINE_INFO_ENABLE = 1'b0;

    // Classified command passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_APPEND,
        OP_LOOKUP,
        OP_CLEAR,
        OP_NOP
    } rlt_op_t;

    typedef struct packed {
        rlt_op_t             op;
        logic [LINE_W-1:0]   line;
        logic [OFFSET_W-1:0] offset;
    } rlt_cmd_t;

    // Back end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } rlt_bk_state_t;

endpackage

// File: rtl/core/rlt_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on rlt_pkg for the payload widths.
`timescale 1ns / 1ps

interface rlt_req_if;
    logic                         valid;
    logic                         ready;
    logic [rlt_pkg::MODE_W-1:0]   mode;
    logic [rlt_pkg::LINE_W-1:0]   line_number;
    logic [rlt_pkg::OFFSET_W-1:0] offset;

    modport source (output valid, output mode, output line_number, output offset,
                    input ready);
    modport sink   (input valid, input mode, input line_number, input offset,
                    output ready);
endinterface

interface rlt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rlt_pkg::LINE_W-1:0]   line_found;
    logic [rlt_pkg::STATUS_W-1:0] status;

    modport source (output valid, output line_found, output status, input ready);
    modport sink   (input valid, input line_found, input status, output ready);
endinterface

// File: rtl/core/rlt_front.sv
// Front end: accepts request transactions and classifies them into commands.
// Depends on rlt_pkg and rlt_req_if.
`timescale 1ns / 1ps

module rlt_front #(
    parameter int LINE_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    rlt_req_if.sink           req,
    input  logic              line_info_enable,
    output rlt_pkg::rlt_cmd_t cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    import rlt_pkg::*;

    // Lines are kept to LINE_BITS bits; wider settings keep the whole field.
    localparam logic [LINE_W-1:0] LINE_MASK = (LINE_BITS >= LINE_W) ? {LINE_W{1'b1}} :
        LINE_W'((64'd1 << LINE_BITS) - 64'd1);

    rlt_cmd_t cmd_reg, cmd_next;
    logic     valid_reg;
    logic     take;

    assign req.ready = !valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;

    // Decode the mode; disabled appends and lookups turn into no-ops.
    always_comb
    begin
        cmd_next.line   = req.line_number & LINE_MASK;
        cmd_next.offset = req.offset;
        unique case (req.mode)
            MODE_APPEND: cmd_next.op = line_info_enable ? OP_APPEND : OP_NOP;
            MODE_LOOKUP: cmd_next.op = line_info_enable ? OP_LOOKUP : OP_NOP;
            MODE_CLEAR:  cmd_next.op = OP_CLEAR;
            default:     cmd_next.op = OP_NOP;
        endcase
    end

    // Holding register for one classified command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

// File: rtl/core/rlt_cmd_queue.sv
// Two-entry command queue that decouples the front end from the back end.
// Depends on rlt_pkg for the command type.
`timescale 1ns / 1ps

module rlt_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  rlt_pkg::rlt_cmd_t push_cmd,
    input  logic              push_valid,
    output logic              push_ready,
    output rlt_pkg::rlt_cmd_t pop_cmd,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import rlt_pkg::*;

    rlt_cmd_t   slot_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/rlt_back.sv
// Back end: executes commands against the run table and drives responses.
// Depends on rlt_pkg and rlt_rsp_if; holds the closed-run memories.
`timescale 1ns / 1ps

module rlt_back #(
    parameter int MAX_RUNS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rlt_pkg::rlt_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    rlt_rsp_if.source         rsp
);
    import rlt_pkg::*;

    localparam int RUN_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam logic [RUN_W-1:0] LAST_IDX = RUN_W'(MAX_RUNS - 1);

    // Closed runs live in memory; the newest run lives in the head registers.
    logic [LINE_W-1:0] run_line_mem [MAX_RUNS];
    logic [LINE_W-1:0] run_len_mem  [MAX_RUNS];

    rlt_bk_state_t       state_reg, state_next;
    logic [RUN_W-1:0]    last_run_reg, last_run_next;
    logic [OFFSET_W-1:0] total_reg, total_next;
    logic [LINE_W-1:0]   head_line_reg, head_line_next;
    logic [LINE_W-1:0]   head_len_reg, head_len_next;
    logic [OFFSET_W-1:0] rest_reg, rest_next;
    logic [RUN_W-1:0]    rd_addr_reg, rd_addr_next;
    logic                rd_vld_reg;
    logic [LINE_W-1:0]   rd_line_reg;
    logic [LINE_W-1:0]   rd_len_reg;
    logic                out_valid_reg, out_valid_next;
    logic [LINE_W-1:0]   out_line_reg, out_line_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic slot_free;
    logic start;
    logic more;
    logic hit;
    logic walk_done;
    logic rd_en;
    logic fresh;
    logic mem_we;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign start     = (state_reg == BK_IDLE) && slot_free && cmd_valid;
    assign cmd_ready = (state_reg == BK_IDLE) && slot_free;

    // Walk status: more closed runs to read, a hit on the returned run, or the end.
    assign more      = (rd_addr_reg < last_run_reg);
    assign hit       = rd_vld_reg && ({{(OFFSET_W-LINE_W){1'b0}}, rd_len_reg} > rest_reg);
    assign walk_done = hit || (!rd_vld_reg && !more);
    assign fresh     = ((head_line_reg != '0) && (head_line_reg != cmd.line)) ||
                       (head_len_reg == RUN_LEN_MAX);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start && (cmd.op == OP_LOOKUP) && (cmd.offset < total_reg))
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (walk_done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        last_run_next   = last_run_reg;
        total_next      = total_reg;
        head_line_next  = head_line_reg;
        head_len_next   = head_len_reg;
        rest_next       = rest_reg;
        rd_addr_next    = rd_addr_reg;
        rd_en           = 1'b0;
        mem_we          = 1'b0;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_line_next   = out_line_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    out_line_next   = '0;
                    out_status_next = ST_OK;
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (total_reg == TOTAL_MAX)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else if (fresh && (last_run_reg == LAST_IDX))
                            begin
                                out_status_next = ST_FULL;
                            end
                            else if (fresh)
                            begin
                                mem_we         = 1'b1;
                                last_run_next  = last_run_reg + RUN_W'(1);
                                head_line_next = cmd.line;
                                head_len_next  = LINE_W'(1);
                                total_next     = total_reg + OFFSET_W'(1);
                            end
                            else
                            begin
                                head_line_next = cmd.line;
                                head_len_next  = head_len_reg + LINE_W'(1);
                                total_next     = total_reg + OFFSET_W'(1);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (cmd.offset < total_reg)
                            begin
                                rest_next    = cmd.offset;
                                rd_addr_next = '0;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_NOREC;
                            end
                        end
                        OP_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            last_run_next  = '0;
                            total_next     = '0;
                            head_line_next = '0;
                            head_len_next  = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            BK_WALK:
            begin
                // One closed run is read per cycle; the head run ends the walk.
                rd_en = more && !hit;
                if (rd_en)
                begin
                    rd_addr_next = rd_addr_reg + RUN_W'(1);
                end
                if (rd_vld_reg && !hit)
                begin
                    rest_next = rest_reg - {{(OFFSET_W-LINE_W){1'b0}}, rd_len_reg};
                end
                if (walk_done)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_line_next   = hit ? rd_line_reg : head_line_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            last_run_reg  <= '0;
            total_reg     <= '0;
            head_line_reg <= '0;
            head_len_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_run_reg  <= last_run_next;
            total_reg     <= total_next;
            head_line_reg <= head_line_next;
            head_len_reg  <= head_len_next;
            rd_vld_reg    <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk and response payload registers.
    always_ff @(posedge clk)
    begin
        rest_reg       <= rest_next;
        rd_addr_reg    <= rd_addr_next;
        out_line_reg   <= out_line_next;
        out_status_reg <= out_status_next;
    end

    // Closed-run memory: the head run is written out when a new run opens.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            run_line_mem[last_run_reg] <= head_line_reg;
            run_len_mem[last_run_reg]  <= head_len_reg;
        end
        if (rd_en)
        begin
            rd_line_reg <= run_line_mem[rd_addr_reg];
            rd_len_reg  <= run_len_mem[rd_addr_reg];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.line_found = out_line_reg;
    assign rsp.status     = out_status_reg;

endmodule

// File: rtl/core/rle_line_table_core.sv
// Top level of the run-length line table: APB register, front end, queue, back end.
// Depends on rlt_pkg, rlt_if, rlt_front, rlt_cmd_queue and rlt_back.
`timescale 1ns / 1ps

// The core records one source line per emitted code word as a table of runs
// and answers which line covers a given code word offset. A request passes a
// one-entry front register and a two-entry command queue before the back end
// executes it. A lookup keeps the back end busy while the walk reads the run
// memory one closed run per cycle, from the first run until a run holds the
// offset or the head run ends the walk. Lookups of unrecorded offsets answer
// without a walk.
// The newest run is kept in registers, so no clearing pass follows reset and
// the core accepts requests as soon as reset is released. The
// line_info_enable register (byte address 0, reset 1) may be written only
// while no request is in flight.
module rle_line_table_core #(
    parameter int MAX_RUNS  = 256,
    parameter int LINE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rlt_req_if.sink     req,
    rlt_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rlt_pkg::*;

    logic     enable_reg;
    logic     cfg_write;
    rlt_cmd_t front_cmd;
    logic     front_valid;
    logic     front_ready;
    rlt_cmd_t queue_cmd;
    logic     queue_valid;
    logic     queue_ready;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_write && (paddr[2] == REG_LINE_INFO_ENABLE))
        begin
            enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_LINE_INFO_ENABLE) ? {31'd0, enable_reg} : 32'd0;

    // Request classification.
    rlt_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req),
        .line_info_enable (enable_reg),
        .cmd              (front_cmd),
        .cmd_valid        (front_valid),
        .cmd_ready        (front_ready)
    );

    // Decoupling queue.
    rlt_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (queue_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    // Table execution.
    rlt_back #(
        .MAX_RUNS (MAX_RUNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .rsp       (rsp)
    );

endmodule

// File: tb/rle_line_table_core_test.sv
// Self-checking testbench for rle_line_table_core: directed table rows, a
// table-full burst, then random traffic checked against a predictor.
// Depends on rlt_pkg, rlt_if and the rle_line_table_core RTL.
`timescale 1ns / 1ps

module rle_line_table_core_test;

    import rlt_pkg::*;

    localparam time HALF_PERIOD    = 5ns;
    localparam int  RESET_CYCLES   = 10;
    localparam int  MAX_RUNS       = 256;
    localparam int  MAX_WAIT       = 12;
    localparam int  SQUEEZE_CYCLES = 300;
    localparam int  SETTLE_CYCLES  = 8;
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  STUCK_LIMIT    = 4000;

    // Mode code that the block decodes as a no-op.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] ENABLE_ADDR = 3'(4 * REG_LINE_INFO_ENABLE);

    typedef enum logic [1:0] {
        KEEP_CFG,
        ENABLE_OFF,
        ENABLE_ON
    } cfg_act_t;

    typedef struct packed {
        logic [LINE_W-1:0]   line_found;
        logic [STATUS_W-1:0] status;
    } answer_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [LINE_W-1:0]   line_number;
        logic [OFFSET_W-1:0] offset;
        logic                typed;
        answer_t             want;
    } req_item_t;

    typedef struct packed {
        cfg_act_t            act;
        logic [MODE_W-1:0]   mode;
        logic [LINE_W-1:0]   line_number;
        logic [OFFSET_W-1:0] offset;
        logic                typed;
        logic [LINE_W-1:0]   want_line;
        logic [STATUS_W-1:0] want_status;
    } row_t;

    localparam int DIRECTED_COUNT = 25;

    // Directed rows. Rows with typed = 0 are checked against the predictor.
    localparam row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        // Lookup on the empty table.
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'h000000, 1'b1, 16'h0000, ST_NOREC},
        // A zero line extends run zero, then the zero run takes the next line.
        '{KEEP_CFG,   MODE_APPEND, 16'h0000, 24'h000000, 1'b1, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_APPEND, 16'hFFFF, 24'hFFFFFF, 1'b1, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_LOOKUP, 16'hFFFF, 24'h000000, 1'b0, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_APPEND, 16'h0001, 24'h000000, 1'b1, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_APPEND, 16'h0001, 24'h000000, 1'b1, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'h000002, 1'b0, 16'h0000, ST_OK},
        // Offsets at and far beyond the recorded count.
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'h000004, 1'b1, 16'h0000, ST_NOREC},
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'hFFFFFF, 1'b1, 16'h0000, ST_NOREC},
        // The unused mode changes nothing.
        '{KEEP_CFG,   MODE_UNUSED, 16'hFFFF, 24'hFFFFFF, 1'b1, 16'h0000, ST_OK},
        // A zero line opens a run that the next line then takes over.
        '{KEEP_CFG,   MODE_APPEND, 16'h0000, 24'h000000, 1'b0, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_APPEND, 16'h0007, 24'h000000, 1'b0, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'h000004, 1'b0, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'h000001, 1'b0, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_CLEAR,  16'hFFFF, 24'hFFFFFF, 1'b1, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'h000000, 1'b1, 16'h0000, ST_NOREC},
        '{KEEP_CFG,   MODE_APPEND, 16'hAAAA, 24'h555555, 1'b0, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_APPEND, 16'h5555, 24'hAAAAAA, 1'b0, 16'h0000, ST_OK},
        // Line info disabled: appends store nothing and lookups answer zero.
        '{ENABLE_OFF, MODE_APPEND, 16'h1234, 24'h000000, 1'b1, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'h000000, 1'b1, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'hFFFFFF, 1'b1, 16'h0000, ST_OK},
        // A clear while disabled still empties the table.
        '{KEEP_CFG,   MODE_CLEAR,  16'h0000, 24'h000000, 1'b1, 16'h0000, ST_OK},
        '{ENABLE_ON,  MODE_LOOKUP, 16'h0000, 24'h000000, 1'b1, 16'h0000, ST_NOREC},
        '{KEEP_CFG,   MODE_APPEND, 16'h8000, 24'h000000, 1'b0, 16'h0000, ST_OK},
        '{KEEP_CFG,   MODE_LOOKUP, 16'h0000, 24'h000000, 1'b0, 16'h0000, ST_OK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rlt_req_if req_ch ();
    rlt_rsp_if rsp_ch ();

    // Predicted table contents and register copy.
    logic [LINE_W-1:0] tbl_line [MAX_RUNS];
    int unsigned       tbl_count [MAX_RUNS];
    int unsigned       tbl_newest;
    int unsigned       tbl_total;
    bit                cfg_enable;

    answer_t     pending_answers [$];
    req_item_t   offered;
    int          mismatches = 0;
    int          stuck_cycles = 0;
    int          sent_count = 0;
    int          answer_count = 0;
    int          rsp_wait = 0;
    bit          no_gaps = 1'b0;
    bit          send_calm = 1'b0;
    bit          rsp_calm = 1'b0;
    bit          squeeze = 1'b0;
    logic [LINE_W-1:0] prev_line = '0;

    rle_line_table_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Empties the predicted table, as a clear transaction does.
    function automatic void empty_table();
        tbl_line[0] = '0;
        tbl_count[0] = 0;
        tbl_newest = 0;
        tbl_total = 0;
    endfunction

    // Applies one request to the predicted table and returns its answer.
    function automatic answer_t predict_answer(input req_item_t it);
        answer_t     ans;
        bit          opens;
        bit          hit;
        int unsigned rest;
        int unsigned r;
        ans.line_found = '0;
        ans.status = ST_OK;
        if (it.mode == MODE_APPEND && cfg_enable)
        begin
            opens = (tbl_line[tbl_newest] != '0 && tbl_line[tbl_newest] != it.line_number)
                    || tbl_count[tbl_newest] >= RUN_LEN_MAX;
            if (tbl_total >= TOTAL_MAX || (opens && tbl_newest == MAX_RUNS - 1))
            begin
                ans.status = ST_FULL;
            end
            else
            begin
                if (opens)
                begin
                    tbl_newest++;
                    tbl_count[tbl_newest] = 0;
                end
                tbl_line[tbl_newest] = it.line_number;
                tbl_count[tbl_newest]++;
                tbl_total++;
            end
        end
        else if (it.mode == MODE_LOOKUP && cfg_enable)
        begin
            // Walk the runs from the first until one covers the offset.
            ans.status = ST_NOREC;
            if (it.offset < tbl_total)
            begin
                rest = it.offset;
                hit = 1'b0;
                for (r = 0; r <= tbl_newest && !hit; r++)
                begin
                    if (rest < tbl_count[r])
                    begin
                        hit = 1'b1;
                        ans.line_found = tbl_line[r];
                        ans.status = ST_OK;
                    end
                    else
                    begin
                        rest -= tbl_count[r];
                    end
                end
            end
        end
        else if (it.mode == MODE_CLEAR)
        begin
            empty_table();
        end
        return ans;
    endfunction

    function automatic int draw_wait(input bit calm);
        if (no_gaps || calm)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Offers one request transaction after a random gap and waits for acceptance.
    task automatic send_item(input req_item_t it);
        int gap;
        if (sent_count % 40 == 0)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
        end
        sent_count++;
        gap = draw_wait(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        offered = it;
        req_ch.mode = it.mode;
        req_ch.line_number = it.line_number;
        req_ch.offset = it.offset;
        req_ch.valid = 1'b1;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Waits for the block to drain, then writes line_info_enable and reads it back.
    task automatic set_line_info(input bit en);
        logic [31:0] readback;
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ENABLE_ADDR;
        pwdata = {31'b0, en};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        cfg_enable = en;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (readback !== {31'b0, en})
        begin
            $display("%0t: line_info_enable readback expected %h, got %h",
                     $time, {31'b0, en}, readback);
            mismatches++;
        end
    endtask

    // Predict on each accepted request; check each accepted response.
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (req_ch.valid && req_ch.ready)
        begin
            got = predict_answer(offered);
            pending_answers.push_back(offered.typed ? offered.want : got);
        end
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (answer_count % 40 == 0)
            begin
                rsp_calm = ($urandom_range(0, 3) == 0);
            end
            answer_count++;
            rsp_wait = draw_wait(rsp_calm);
            if (pending_answers.size() == 0)
            begin
                $display("%0t: response with none expected: line_found %h status %0d",
                         $time, rsp_ch.line_found, rsp_ch.status);
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.line_found !== want.line_found)
                begin
                    $display("%0t: line_found expected %h, got %h",
                             $time, want.line_found, rsp_ch.line_found);
                    mismatches++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    mismatches++;
                end
            end
        end
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
        end
    end

    // Response side: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze)
            begin
                hold = SQUEEZE_CYCLES;
                squeeze = 1'b0;
            end
            if (hold > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold--;
            end
            else if (rsp_wait > 0)
            begin
                rsp_ch.ready = 1'b0;
                rsp_wait--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
        $display("rle_line_table_core_test failed");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        int          i;
        int          n;
        int          p;
        int          pick;
        int          sel;
        int          phase_items;
        int unsigned span;
        req_item_t   it;
        row_t        row;

        req_ch.valid = 1'b0;
        req_ch.mode = MODE_APPEND;
        req_ch.line_number = '0;
        req_ch.offset = '0;
        offered = '0;
        for (i = 0; i < MAX_RUNS; i++)
        begin
            tbl_line[i] = '0;
            tbl_count[i] = 0;
        end
        empty_table();
        cfg_enable = 1'b1;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows.
        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.act == ENABLE_OFF)
            begin
                set_line_info(1'b0);
            end
            else if (row.act == ENABLE_ON)
            begin
                set_line_info(1'b1);
            end
            it = '0;
            it.mode = row.mode;
            it.line_number = row.line_number;
            it.offset = row.offset;
            it.typed = row.typed;
            it.want.line_found = row.want_line;
            it.want.status = row.want_status;
            send_item(it);
        end

        // Give every run its own line, push a new line past the full table,
        // then extend the newest run and look up both ends.
        no_gaps = 1'b1;
        it = '0;
        it.mode = MODE_CLEAR;
        send_item(it);
        it.mode = MODE_APPEND;
        for (n = 0; n < MAX_RUNS; n++)
        begin
            it.line_number = 16'(n + 1);
            send_item(it);
        end
        it.line_number = 16'h8000;
        send_item(it);
        it.line_number = 16'(MAX_RUNS);
        send_item(it);
        it.mode = MODE_LOOKUP;
        it.offset = 24'(tbl_total - 1);
        send_item(it);
        it.offset = '0;
        send_item(it);
        no_gaps = 1'b0;

        // Random phases: enabled, disabled, enabled again.
        for (p = 0; p < 3; p++)
        begin
            set_line_info(p != 1);
            phase_items = (p == 1) ? 200 : 600;
            for (n = 0; n < phase_items; n++)
            begin
                if (p == 0 && n == 40)
                begin
                    squeeze = 1'b1;
                end
                it = '0;
                it.line_number = 16'($urandom);
                it.offset = 24'($urandom);
                pick = $urandom_range(0, 99);
                sel = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    // Appends mostly repeat the previous line to build runs.
                    it.mode = MODE_APPEND;
                    if (sel < 55)
                    begin
                        it.line_number = prev_line;
                    end
                    else if (sel < 65)
                    begin
                        it.line_number = '0;
                    end
                    prev_line = it.line_number;
                end
                else if (pick < 97)
                begin
                    // Lookups mostly fall inside the recorded range.
                    it.mode = MODE_LOOKUP;
                    if (tbl_total != 0 && sel >= 15)
                    begin
                        if (sel < 25)
                        begin
                            it.offset = 24'(tbl_total);
                        end
                        else if (sel < 45)
                        begin
                            span = (tbl_total > 300) ? 299 : tbl_total - 1;
                            it.offset = 24'(tbl_total - 1 - $urandom_range(0, span));
                        end
                        else
                        begin
                            it.offset = 24'($urandom_range(0, tbl_total - 1));
                        end
                    end
                end
                else if (pick < 98)
                begin
                    it.mode = MODE_CLEAR;
                end
                else
                begin
                    it.mode = MODE_UNUSED;
                end
                send_item(it);
            end
        end

        // Drain the remaining responses, then report.
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("rle_line_table_core_test passed");
        end
        else
        begin
            $display("rle_line_table_core_test failed");
        end
        $finish;
    end

endmodule
